FILE: rtl/bcsc_pkg.sv
// Shared beat types, operation and status codes, and controller/datapath links.
package bcsc_pkg;

    localparam logic [2:0] K_ALLOT   = 3'd0;
    localparam logic [2:0] K_FETCH   = 3'd1;
    localparam logic [2:0] K_STORE   = 3'd2;
    localparam logic [2:0] K_CAPTURE = 3'd3;
    localparam logic [2:0] K_RESTORE = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] count;
        logic signed [31:0] index;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] fetched_value;
        logic [10:0]        base_address;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic go_loop;
        logic loop_last;
    } t_dp_stat;

endpackage

FILE: rtl/bcsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module bcsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/bcsc_ctrl.sv
// Controller: sequences accept, cell sweep and result hand-off.
module bcsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bcsc_pkg::t_dp_stat i_stat,
    output bcsc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOP = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load, emit;

    assign load = (r_state == S_IDLE) && i_in_valid;
    assign emit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.go_loop ? S_LOOP : S_DONE;
                end
            end
            S_LOOP: begin
                if (i_stat.loop_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load = load;
    assign o_cmd.step = (r_state == S_LOOP);
    assign o_cmd.emit = emit;

endmodule

FILE: rtl/bcsc_dpath.sv
// Datapath: level and mark registers, operation checks, memories and result register.
module bcsc_dpath #(
    parameter int CELL_CAPACITY = 1024,
    parameter int CELL_WIDTH    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcsc_pkg::t_in_beat  i_in_beat,
    input  bcsc_pkg::t_dp_cmd   i_cmd,
    output bcsc_pkg::t_dp_stat  o_stat,
    output bcsc_pkg::t_out_beat o_out_beat
);

    localparam int LW = $clog2(CELL_CAPACITY + 1);
    localparam int AW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;

    logic [LW-1:0] r_level, n_level;
    logic [LW-1:0] r_mark, n_mark;
    logic [LW-1:0] r_ptr, n_ptr;
    logic [LW-1:0] r_last, n_last;
    logic [2:0]    r_kind;
    logic [1:0]    r_status, n_status;
    logic [10:0]   r_base, n_base;
    logic          r_fetch_ok, n_fetch_ok;
    logic          r_cp_pend;
    logic [AW-1:0] r_cp_addr;
    bcsc_pkg::t_out_beat r_out;

    logic [32:0] sum;
    logic        cnt_zero, full, idx_ok, go_loop;

    logic                  cell_we, cell_re, seed_we, seed_re;
    logic [AW-1:0]         cell_waddr, cell_raddr, seed_waddr, seed_raddr;
    logic [CELL_WIDTH-1:0] cell_wdata, cell_rdata, seed_rdata;
    logic [63:0]           store_wide;
    logic signed [CELL_WIDTH-1:0] cell_rd_s;
    logic signed [63:0]    fetch_ext;

    // Operation checks on the incoming beat
    assign sum      = 33'(r_level) + {1'b0, i_in_beat.count};
    assign cnt_zero = (i_in_beat.count == 32'sd0);
    assign full     = (sum > 33'(CELL_CAPACITY));
    assign idx_ok   = !i_in_beat.index[31] && (32'(i_in_beat.index) < 32'(r_level));

    always_comb begin
        go_loop = 1'b0;
        case (i_in_beat.kind)
            bcsc_pkg::K_ALLOT:   go_loop = !i_in_beat.count[31] && !full && !cnt_zero;
            bcsc_pkg::K_CAPTURE: go_loop = (r_level != '0);
            bcsc_pkg::K_RESTORE: go_loop = (r_mark != '0);
            default:             go_loop = 1'b0;
        endcase
    end

    assign o_stat.go_loop   = go_loop;
    assign o_stat.loop_last = (r_ptr == r_last);

    always_comb begin
        n_level    = r_level;
        n_mark     = r_mark;
        n_ptr      = r_ptr;
        n_last     = r_last;
        n_status   = r_status;
        n_base     = r_base;
        n_fetch_ok = r_fetch_ok;
        if (i_cmd.load) begin
            n_status   = bcsc_pkg::ST_OK;
            n_base     = '0;
            n_fetch_ok = 1'b0;
            n_ptr      = '0;
            case (i_in_beat.kind)
                bcsc_pkg::K_ALLOT: begin
                    if (i_in_beat.count[31]) begin
                        n_status = bcsc_pkg::ST_BOUNDS;
                    end else if (full) begin
                        n_status = bcsc_pkg::ST_FULL;
                    end else begin
                        n_base  = 11'(r_level);
                        n_ptr   = r_level;
                        n_last  = LW'(sum - 33'd1);
                        n_level = LW'(sum);
                    end
                end
                bcsc_pkg::K_FETCH: begin
                    if (idx_ok) begin
                        n_fetch_ok = 1'b1;
                    end else begin
                        n_status = bcsc_pkg::ST_BOUNDS;
                    end
                end
                bcsc_pkg::K_STORE: begin
                    if (!idx_ok) begin
                        n_status = bcsc_pkg::ST_BOUNDS;
                    end
                end
                bcsc_pkg::K_CAPTURE: begin
                    n_mark = r_level;
                    n_last = r_level - LW'(1);
                end
                bcsc_pkg::K_RESTORE: begin
                    n_level = r_mark;
                    n_last  = r_mark - LW'(1);
                end
                default: n_status = bcsc_pkg::ST_OK;
            endcase
        end else if (i_cmd.step) begin
            n_ptr = r_ptr + LW'(1);
        end
    end

    // Memory ports: store, zero sweep and copy sweeps never overlap
    assign store_wide = {32'd0, i_in_beat.value};

    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = r_ptr[AW-1:0];
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = r_ptr[AW-1:0];
        seed_we    = 1'b0;
        seed_waddr = r_cp_addr;
        seed_re    = 1'b0;
        seed_raddr = r_ptr[AW-1:0];
        if (i_cmd.load && idx_ok && (i_in_beat.kind == bcsc_pkg::K_STORE)) begin
            cell_we    = 1'b1;
            cell_waddr = i_in_beat.index[AW-1:0];
            cell_wdata = store_wide[CELL_WIDTH-1:0];
        end
        if (i_cmd.load && (i_in_beat.kind == bcsc_pkg::K_FETCH)) begin
            cell_re    = 1'b1;
            cell_raddr = i_in_beat.index[AW-1:0];
        end
        if (i_cmd.step) begin
            case (r_kind)
                bcsc_pkg::K_ALLOT:   cell_we = 1'b1;
                bcsc_pkg::K_CAPTURE: cell_re = 1'b1;
                bcsc_pkg::K_RESTORE: seed_re = 1'b1;
                default:             cell_we = 1'b0;
            endcase
        end
        if (r_cp_pend) begin
            if (r_kind == bcsc_pkg::K_CAPTURE) begin
                seed_we = 1'b1;
            end else begin
                cell_we    = 1'b1;
                cell_waddr = r_cp_addr;
                cell_wdata = seed_rdata;
            end
        end
    end

    assign cell_rd_s = cell_rdata;
    assign fetch_ext = 64'(cell_rd_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_mark    <= '0;
            r_cp_pend <= 1'b0;
        end else begin
            r_level   <= n_level;
            r_mark    <= n_mark;
            r_cp_pend <= i_cmd.step && ((r_kind == bcsc_pkg::K_CAPTURE) ||
                                        (r_kind == bcsc_pkg::K_RESTORE));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_last     <= n_last;
        r_status   <= n_status;
        r_base     <= n_base;
        r_fetch_ok <= n_fetch_ok;
        r_cp_addr  <= r_ptr[AW-1:0];
        if (i_cmd.load) begin
            r_kind <= i_in_beat.kind;
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.fetched_value <= r_fetch_ok ? fetch_ext[31:0] : 32'sd0;
            r_out.base_address  <= r_base;
        end
    end

    assign o_out_beat = r_out;

    bcsc_ram #(.WIDTH(CELL_WIDTH), .DEPTH(CELL_CAPACITY)) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cell_we),
        .i_wr_addr (cell_waddr),
        .i_wr_data (cell_wdata),
        .i_rd_en   (cell_re),
        .i_rd_addr (cell_raddr),
        .o_rd_data (cell_rdata)
    );

    bcsc_ram #(.WIDTH(CELL_WIDTH), .DEPTH(CELL_CAPACITY)) u_seed_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seed_we),
        .i_wr_addr (seed_waddr),
        .i_wr_data (cell_rdata),
        .i_rd_en   (seed_re),
        .i_rd_addr (seed_raddr),
        .o_rd_data (seed_rdata)
    );

endmodule

FILE: rtl/bump_cell_store_with_checkpoint.sv
// Top level of the bump-allocated cell store with one checkpoint.
//
// A store of CELL_CAPACITY cells, CELL_WIDTH bits each, filled from the bottom
// by a bump pointer. Every input beat carries one operation and yields exactly
// one result beat. Allot grants count fresh zeroed cells at the fill level and
// returns the old level as base; a negative count answers bounds error, one
// that would pass capacity answers store full. Fetch and store touch one cell
// below the fill level, else bounds error. Capture copies the used cells into
// the seed memory and records the level as the mark; restore copies the seed
// cells back and sets the level to the mark. Unused kinds answer ok with zero
// fields. One item is worked on at a time: fetch, store, failed or empty
// allots and empty checkpoints go straight from accept to the result state;
// an allot first sweeps its fresh cells, a capture the used cells and a
// restore the cells below the mark, one at a time through the single write
// port of the cell or seed RAM. The result sits in an output register, so the
// next beat may be accepted while it still waits for the consumer. Both
// memories are undefined after reset and need no clearing pass.
module bump_cell_store_with_checkpoint #(
    parameter int CELL_CAPACITY = 1024,
    parameter int CELL_WIDTH    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bcsc_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bcsc_pkg::t_out_beat o_out_beat
);

    bcsc_pkg::t_dp_cmd  cmd;
    bcsc_pkg::t_dp_stat stat;

    // Sequence accept, sweep and hand-off
    bcsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the level, mark, memories and the result register
    bcsc_dpath #(
        .CELL_CAPACITY (CELL_CAPACITY),
        .CELL_WIDTH    (CELL_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (i_in_beat),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_beat (o_out_beat)
    );

endmodule

FILE: rtl/bcsc_chk.sv
// Port-level checker for the cell store, bound to the top level.
module bcsc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input bcsc_pkg::t_in_beat  i_in_beat,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bcsc_pkg::t_out_beat o_out_beat
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // Drop the result after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // An error carries zero fields and a defined code
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != bcsc_pkg::ST_OK) |->
        (o_out_beat.fetched_value == 32'sd0) && (o_out_beat.base_address == 11'd0) &&
        ((o_out_beat.status == bcsc_pkg::ST_BOUNDS) || (o_out_beat.status == bcsc_pkg::ST_FULL)))
        else $error("error result with nonzero fields or unknown status");

endmodule

bind bump_cell_store_with_checkpoint bcsc_chk u_bcsc_chk (.*);

FILE: bench/tb_bump_cell_store_with_checkpoint.sv
// Self-checking bench for the bump-allocated cell store with one checkpoint.
module tb_bump_cell_store_with_checkpoint;

    localparam int CAPACITY     = 1024;
    // Slowest legal item is a full sweep of 1024 cells; allow every item that
    // much plus stalls, several times over.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES  = 1100;

    // Kinds the block answers with ok and zero fields.
    localparam logic [2:0] K_UNUSED_A = 3'd5;
    localparam logic [2:0] K_UNUSED_B = 3'd6;
    localparam logic [2:0] K_UNUSED_C = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    bcsc_pkg::t_in_beat  i_in_beat = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    bcsc_pkg::t_out_beat o_out_beat;

    // Shadow of the store, advanced once per accepted beat.
    logic [31:0] cell_image [CAPACITY];
    logic [31:0] seed_image [CAPACITY];
    int          fill_now = 0;
    int          mark_now = 0;

    bcsc_pkg::t_out_beat awaited_results [$];
    bcsc_pkg::t_out_beat want_beat;
    int          fault_count = 0;
    int          cycle_count = 0;
    // High while neither side may idle.
    logic        calm = 1'b0;

    bump_cell_store_with_checkpoint #(
        .CELL_CAPACITY(CAPACITY),
        .CELL_WIDTH   (32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    always #2 i_clk = ~i_clk;

    // Apply one operation to the shadow store and return the beat it must answer.
    function automatic bcsc_pkg::t_out_beat apply_cell_op(input bcsc_pkg::t_in_beat b);
        bcsc_pkg::t_out_beat r;
        longint    cnt;
        int        idx;
        r   = '0;
        cnt = longint'($signed(b.count));
        idx = $signed(b.index);
        case (b.kind)
            bcsc_pkg::K_ALLOT: begin
                // Sum is taken at 64 bits, so a huge count can never wrap past the check.
                if (cnt < 0) begin
                    r.status = bcsc_pkg::ST_BOUNDS;
                end else if (longint'(fill_now) + cnt > CAPACITY) begin
                    r.status = bcsc_pkg::ST_FULL;
                end else begin
                    r.base_address = 11'(fill_now);
                    for (int i = fill_now; i < fill_now + int'(cnt); i++) cell_image[i] = '0;
                    fill_now += int'(cnt);
                end
            end
            bcsc_pkg::K_FETCH: begin
                if (idx < 0 || idx >= fill_now) r.status = bcsc_pkg::ST_BOUNDS;
                else r.fetched_value = cell_image[idx];
            end
            bcsc_pkg::K_STORE: begin
                if (idx < 0 || idx >= fill_now) r.status = bcsc_pkg::ST_BOUNDS;
                else cell_image[idx] = b.value;
            end
            bcsc_pkg::K_CAPTURE: begin
                for (int i = 0; i < fill_now; i++) seed_image[i] = cell_image[i];
                mark_now = fill_now;
            end
            bcsc_pkg::K_RESTORE: begin
                for (int i = 0; i < mark_now; i++) cell_image[i] = seed_image[i];
                fill_now = mark_now;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one beat at the falling edge, hold it until accepted, then record
    // what the block owes for it.
    task automatic send_beat(input logic [2:0] kind, input logic [31:0] count,
                             input logic [31:0] index, input logic [31:0] value);
        bcsc_pkg::t_in_beat b;
        b.kind  = kind;
        b.count = count;
        b.index = index;
        b.value = value;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_results.push_back(apply_cell_op(b));
    endtask

    // Drop valid and hold until every owed result has been taken.
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick an operation with fields aimed at the current fill level.
    task automatic send_random_op();
        int          r;
        int          pick;
        logic [2:0]  kind;
        logic [31:0] count;
        logic [31:0] index;
        r     = $urandom_range(0, 99);
        pick  = $urandom_range(0, 99);
        count = $urandom;
        index = $urandom;
        if (r < 28) kind = bcsc_pkg::K_ALLOT;
        else if (r < 54) kind = bcsc_pkg::K_FETCH;
        else if (r < 80) kind = bcsc_pkg::K_STORE;
        else if (r < 88) kind = bcsc_pkg::K_CAPTURE;
        else if (r < 96) kind = bcsc_pkg::K_RESTORE;
        else kind = 3'($urandom_range(K_UNUSED_A, K_UNUSED_C));
        if (kind == bcsc_pkg::K_ALLOT) begin
            if (pick < 60) count = $urandom_range(0, 6);
            else if (pick < 72) count = $urandom_range(7, 40);
            else if (pick < 74) count = CAPACITY - fill_now;
            else if (pick < 82) count = 32'h8000_0000 | $urandom;
            else if (pick < 92) count = $urandom;
            else count = CAPACITY - fill_now + 1;
        end else if (kind == bcsc_pkg::K_FETCH || kind == bcsc_pkg::K_STORE) begin
            if (fill_now > 0 && pick < 75) index = $urandom_range(0, fill_now - 1);
            else if (pick < 82) index = fill_now;
            else if (pick < 86) index = 32'hFFFF_FFFF;
            else if (pick < 90) index = (fill_now > 0) ? fill_now - 1 : 0;
        end
        send_beat(kind, count, index, $urandom);
    endtask

    // Allot edges: empty grant, negative counts, counts that cannot fit.
    task automatic test_allot_limits();
        send_beat(bcsc_pkg::K_ALLOT, 32'd0, $urandom, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd0, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'hFFFF_FFFF, $urandom, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'h8000_0000, $urandom, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'h7FFF_FFFF, $urandom, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'd4, $urandom, $urandom);
    endtask

    // Cell access at the value extremes and just outside the used cells.
    task automatic test_fetch_store_bounds();
        send_beat(bcsc_pkg::K_STORE, $urandom, 32'd0, 32'h7FFF_FFFF);
        send_beat(bcsc_pkg::K_STORE, $urandom, 32'd3, 32'h8000_0000);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd0, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd3, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd2, $urandom);
        send_beat(bcsc_pkg::K_STORE, $urandom, 32'hFFFF_FFFF, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd4, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'h8000_0000, $urandom);
    endtask

    // Capture, disturb both cells and level, then restore and read back.
    task automatic test_checkpoint();
        send_beat(bcsc_pkg::K_CAPTURE, $urandom, $urandom, $urandom);
        send_beat(bcsc_pkg::K_STORE, $urandom, 32'd0, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'd2, $urandom, $urandom);
        send_beat(bcsc_pkg::K_RESTORE, $urandom, $urandom, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd0, $urandom);
        send_beat(bcsc_pkg::K_FETCH, $urandom, 32'd4, $urandom);
    endtask

    task automatic test_unused_kinds();
        send_beat(K_UNUSED_A, $urandom, $urandom, $urandom);
        send_beat(K_UNUSED_B, $urandom, $urandom, $urandom);
        send_beat(K_UNUSED_C, $urandom, $urandom, $urandom);
    endtask

    // Fill to exactly capacity, then probe the full store and fall back.
    task automatic test_fill_to_capacity();
        send_beat(bcsc_pkg::K_ALLOT, CAPACITY - fill_now, $urandom, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'd1, $urandom, $urandom);
        send_beat(bcsc_pkg::K_ALLOT, 32'd0, $urandom, $urandom);
        send_beat(bcsc_pkg::K_RESTORE, $urandom, $urandom, $urandom);
    endtask

    // Let the result side empty out completely in the middle of traffic.
    task automatic test_drain_pause();
        repeat (4) send_random_op();
        pause_until_drained();
        repeat (4) send_random_op();
    endtask

    // Rounds of mixed traffic; some open with a restore to pull the level down,
    // one runs with no idling at all, some end with a full drain.
    task automatic test_random_rounds();
        for (int round = 0; round < 15; round++) begin
            calm = (round == 5);
            if ($urandom_range(0, 1) == 1) begin
                send_beat(bcsc_pkg::K_RESTORE, $urandom, $urandom, $urandom);
            end
            repeat (34) send_random_op();
            if (round % 4 == 3) pause_until_drained();
        end
        calm = 1'b0;
    endtask

    // Receiver: stall at random on the falling edge unless the calm stretch is on.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // Check each taken result against the oldest one owed; stop on runaway.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL bump_cell_store_with_checkpoint");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with none owed: status %0d", o_out_beat.status);
                fault_count++;
            end else begin
                want_beat = awaited_results.pop_front();
                if (o_out_beat.status !== want_beat.status) begin
                    $error("status: expected %0d, got %0d",
                           want_beat.status, o_out_beat.status);
                    fault_count++;
                end
                if (o_out_beat.fetched_value !== want_beat.fetched_value) begin
                    $error("fetched_value: expected %0d, got %0d",
                           want_beat.fetched_value, o_out_beat.fetched_value);
                    fault_count++;
                end
                if (o_out_beat.base_address !== want_beat.base_address) begin
                    $error("base_address: expected %0d, got %0d",
                           want_beat.base_address, o_out_beat.base_address);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_allot_limits();
        test_fetch_store_bounds();
        test_checkpoint();
        test_unused_kinds();
        test_fill_to_capacity();
        test_drain_pause();
        test_random_rounds();

        // Hold until all results are in, then watch for strays over a full sweep.
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("PASS bump_cell_store_with_checkpoint");
        end else begin
            $display("FAIL bump_cell_store_with_checkpoint");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/bcsc_pkg.sv
rtl/bcsc_ram.sv
rtl/bcsc_ctrl.sv
rtl/bcsc_dpath.sv
rtl/bump_cell_store_with_checkpoint.sv
rtl/bcsc_chk.sv
bench/tb_bump_cell_store_with_checkpoint.sv
